### design/exlex_pkg.sv
// exlex_pkg: shared types and constants for the expression lexer.
// Payload structs, token kinds, character codes and scan states.
// No dependencies.
package exlex_pkg;

   localparam int LINE_BITS         = 20;
   localparam int COLUMN_BITS       = 16;
   localparam int MID_DEPTH_DEFAULT = 2;
   localparam int OUT_DEPTH_DEFAULT = 2;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_US     = 8'h5F;

   // token kinds
   localparam logic [4:0] KIND_OTHER   = 5'd0;
   localparam logic [4:0] KIND_CHAR    = 5'd1;
   localparam logic [4:0] KIND_NUMBER  = 5'd2;
   localparam logic [4:0] KIND_IDENT   = 5'd3;
   localparam logic [4:0] KIND_SEMI    = 5'd4;
   localparam logic [4:0] KIND_LPAREN  = 5'd5;
   localparam logic [4:0] KIND_RPAREN  = 5'd6;
   localparam logic [4:0] KIND_LBRACK  = 5'd7;
   localparam logic [4:0] KIND_RBRACK  = 5'd8;
   localparam logic [4:0] KIND_COMMA   = 5'd9;
   localparam logic [4:0] KIND_OR      = 5'd10;
   localparam logic [4:0] KIND_AND     = 5'd11;
   localparam logic [4:0] KIND_XOR     = 5'd12;
   localparam logic [4:0] KIND_NOT     = 5'd13;
   localparam logic [4:0] KIND_EQ      = 5'd14;
   localparam logic [4:0] KIND_PLUS    = 5'd15;
   localparam logic [4:0] KIND_MINUS   = 5'd16;
   localparam logic [4:0] KIND_MUL     = 5'd17;
   localparam logic [4:0] KIND_DIV     = 5'd18;
   localparam logic [4:0] KIND_MOD     = 5'd19;
   localparam logic [4:0] KIND_LT      = 5'd20;
   localparam logic [4:0] KIND_LTLT    = 5'd21;
   localparam logic [4:0] KIND_LE      = 5'd22;
   localparam logic [4:0] KIND_GT      = 5'd23;
   localparam logic [4:0] KIND_GTGT    = 5'd24;
   localparam logic [4:0] KIND_GE      = 5'd25;
   localparam logic [4:0] KIND_COLONEQ = 5'd26;
   localparam logic [4:0] KIND_ERROR   = 5'd27;
   localparam logic [4:0] KIND_EOF     = 5'd28;

   typedef enum logic [3:0] {
      ST_START, ST_NUM, ST_ID, ST_LT, ST_GT, ST_ASSIGN, ST_SLASH,
      ST_BSLASH, ST_LINECMT, ST_BLOCK, ST_BLOCKSTAR
   } scan_state_type;

   typedef enum logic [3:0] {
      CC_EOF, CC_DIGIT, CC_ALPHA, CC_BLANK, CC_NEWLINE, CC_BSLASH, CC_SLASH,
      CC_STAR, CC_LT, CC_GT, CC_COLON, CC_EQ, CC_OP, CC_OTHER
   } char_class_type;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]             token_kind;
      logic [7:0]             char_value;
      logic [LINE_BITS-1:0]   line_number;
      logic [COLUMN_BITS-1:0] start_column;
      logic                   last_of_run;
   } rsp_type;

   // classified character handed from front end to back end
   typedef struct packed {
      char_class_type         cls;
      logic [7:0]             ch;
      logic [4:0]             op_kind;
      logic [COLUMN_BITS-1:0] column;
   } item_type;

endpackage

### design/expression_lexer.sv
// expression_lexer: top level of the streaming expression lexer.
// Instantiates exlex_front, exlex_fifo (twice) and exlex_back; uses exlex_pkg.
//
// Streaming lexer: push one source byte (or an end-of-input mark) per
// transfer on req_, pop result items on rsp_. Input is taken at one item
// per clock as long as the results are drained; an item that yields two
// results (a lexeme end followed by the token of the byte that ended it)
// holds the back end until both are written, since the back end writes one
// result per cycle into the result queue. The first result of an item
// reaches rsp_ via both queues. CRLF's LF is absorbed without a result.
// Line and column counts saturate at all ones and start at line 1, col 0.
module expression_lexer #(
   parameter int MID_DEPTH = exlex_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = exlex_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // input channel: transfer when req_push && !req_full
   input  logic               req_push,
   input  exlex_pkg::req_type req_data,
   output logic               req_full,
   // result channel: transfer when rsp_pop && !rsp_empty
   input  logic               rsp_pop,
   output exlex_pkg::rsp_type rsp_data,
   output logic               rsp_empty
);
   import exlex_pkg::*;

   logic     mid_push, mid_full, mid_pop, mid_empty;
   item_type mid_in, mid_out;
   logic     out_push, out_full;
   rsp_type  out_in;

   // front end: CR folding, column tracking, character classes
   exlex_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_data (mid_in)
   );

   // the front stalls only on this queue
   assign req_full = mid_full;

   exlex_fifo #(
      .DATA_TYPE (item_type),
      .DEPTH     (MID_DEPTH)
   ) u_mid_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (mid_push),
      .data_in  (mid_in),
      .full     (mid_full),
      .pop      (mid_pop),
      .data_out (mid_out),
      .empty    (mid_empty)
   );

   // back end: scan states, line count, token boundaries
   exlex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_out),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_in)
   );

   // result queue decouples the consumer from the back end
   exlex_fifo #(
      .DATA_TYPE (rsp_type),
      .DEPTH     (OUT_DEPTH)
   ) u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .data_in  (out_in),
      .full     (out_full),
      .pop      (rsp_pop),
      .data_out (rsp_data),
      .empty    (rsp_empty)
   );

endmodule

### design/exlex_fifo.sv
// exlex_fifo: small first-word-fall-through queue with registered storage.
// Used between front and back ends and at the result side. No package use.
module exlex_fifo #(
   parameter type DATA_TYPE = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  DATA_TYPE data_in,
   output logic     full,
   input  logic     pop,
   output DATA_TYPE data_out,
   output logic     empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

   DATA_TYPE            mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

### design/exlex_front.sv
// exlex_front: accepts source bytes, folds CR/CRLF, tracks the column
// and classifies each character. Depends on exlex_pkg.
module exlex_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  exlex_pkg::req_type  req_data,
   input  logic                mid_full,
   output logic                mid_push,
   output exlex_pkg::item_type mid_data
);
   import exlex_pkg::*;

   localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

   logic                   cr_seen_ff, cr_seen_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic                   accept, drop, is_eof;
   logic [7:0]             ch;

   function automatic logic [4:0] single_op_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h3B:   k = KIND_SEMI;    // ;
         8'h28:   k = KIND_LPAREN;  // (
         8'h29:   k = KIND_RPAREN;  // )
         8'h5B:   k = KIND_LBRACK;  // [
         8'h5D:   k = KIND_RBRACK;  // ]
         8'h2C:   k = KIND_COMMA;   // ,
         8'h7C:   k = KIND_OR;      // |
         8'h26:   k = KIND_AND;     // &
         8'h5E:   k = KIND_XOR;     // ^
         8'h7E:   k = KIND_NOT;     // ~
         8'h3D:   k = KIND_EQ;      // =
         8'h2B:   k = KIND_PLUS;    // +
         8'h2D:   k = KIND_MINUS;   // -
         8'h2A:   k = KIND_MUL;     // *
         8'h25:   k = KIND_MOD;     // %
         default: k = KIND_OTHER;
      endcase
      return k;
   endfunction

   function automatic char_class_type classify(logic [7:0] c, logic [4:0] op);
      char_class_type cc;
      if (c >= 8'h30 && c <= 8'h39) cc = CC_DIGIT;
      else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US)
         cc = CC_ALPHA;
      else if (c == CH_SPACE || c == CH_TAB) cc = CC_BLANK;
      else if (c == CH_LF)     cc = CC_NEWLINE;
      else if (c == CH_BSLASH) cc = CC_BSLASH;
      else if (c == CH_SLASH)  cc = CC_SLASH;
      else if (c == CH_LT)     cc = CC_LT;
      else if (c == CH_GT)     cc = CC_GT;
      else if (c == CH_COLON)  cc = CC_COLON;
      else if (c == CH_STAR)   cc = CC_STAR;
      else if (c == CH_EQ)     cc = CC_EQ;
      else if (op != KIND_OTHER) cc = CC_OP;
      else cc = CC_OTHER;
      return cc;
   endfunction

   assign accept = req_push & ~mid_full;
   assign is_eof = req_data.end_of_input;
   // LF right after CR is swallowed: no item, no column step
   assign drop   = ~is_eof & (req_data.source_byte == CH_LF) & cr_seen_ff;
   assign ch     = (req_data.source_byte == CH_CR) ? CH_LF : req_data.source_byte;

   always_comb begin
      cr_seen_in = cr_seen_ff;
      column_in  = column_ff;
      if (accept) begin
         if (!is_eof) begin
            cr_seen_in = drop ? 1'b0 : (req_data.source_byte == CH_CR);
         end
         if (!drop) begin
            // every newline starts a new line whatever the scan state
            if (!is_eof && ch == CH_LF) begin
               column_in = '0;
            end else begin
               column_in = (column_ff == COL_MAX) ? column_ff : column_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      mid_push         = accept & ~drop;
      mid_data.op_kind = single_op_kind(ch);
      mid_data.cls     = is_eof ? CC_EOF : classify(ch, mid_data.op_kind);
      mid_data.ch      = ch;
      mid_data.column  = (column_ff == COL_MAX) ? column_ff : column_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_seen_ff <= 1'b0;
         column_ff  <= '0;
      end else begin
         cr_seen_ff <= cr_seen_in;
         column_ff  <= column_in;
      end
   end

endmodule

### design/exlex_back.sv
// exlex_back: scan state machine, line count and token start column.
// Writes up to two results per item into the result queue. Uses exlex_pkg.
module exlex_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                mid_empty,
   input  exlex_pkg::item_type mid_data,
   output logic                mid_pop,
   input  logic                out_full,
   output logic                out_push,
   output exlex_pkg::rsp_type  out_data
);
   import exlex_pkg::*;

   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   typedef struct packed {
      logic           emit;
      logic [4:0]     kind;
      logic [7:0]     ch;
      scan_state_type next;
      logic           again;
      logic           newline;
      logic           start;
   } pass_type;

   scan_state_type         state_ff, state_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] tok_col_ff, tok_col_in;
   logic                   phase_ff, phase_in;
   pass_type               p1, p2;
   logic                   second, both;
   rsp_type                r1, r2;

   function automatic pass_type scan_pass(scan_state_type st, item_type it);
      pass_type p;
      p = '{emit: 1'b0, kind: KIND_OTHER, ch: 8'h00, next: st,
            again: 1'b0, newline: 1'b0, start: 1'b0};
      case (st)
         ST_NUM: begin
            if (it.cls == CC_DIGIT) begin
               p.emit = 1'b1; p.kind = KIND_CHAR; p.ch = it.ch;
            end else begin
               p.emit = 1'b1; p.kind = KIND_NUMBER; p.next = ST_START; p.again = 1'b1;
            end
         end
         ST_ID: begin
            if (it.cls == CC_DIGIT || it.cls == CC_ALPHA) begin
               p.emit = 1'b1; p.kind = KIND_CHAR; p.ch = it.ch;
            end else begin
               p.emit = 1'b1; p.kind = KIND_IDENT; p.next = ST_START; p.again = 1'b1;
            end
         end
         ST_LT, ST_GT: begin
            p.emit = 1'b1;
            p.next = ST_START;
            if ((st == ST_LT && it.cls == CC_LT) || (st == ST_GT && it.cls == CC_GT))
               p.kind = (st == ST_LT) ? KIND_LTLT : KIND_GTGT;
            else if (it.cls == CC_EQ)
               p.kind = (st == ST_LT) ? KIND_LE : KIND_GE;
            else begin
               p.kind  = (st == ST_LT) ? KIND_LT : KIND_GT;
               p.again = 1'b1;
            end
         end
         ST_ASSIGN: begin
            p.emit = 1'b1;
            p.next = ST_START;
            if (it.cls == CC_EQ) p.kind = KIND_COLONEQ;
            else begin
               p.kind  = KIND_ERROR;
               p.again = 1'b1;
            end
         end
         ST_SLASH: begin
            if (it.cls == CC_SLASH) p.next = ST_LINECMT;
            else if (it.cls == CC_STAR) p.next = ST_BLOCK;
            else begin
               p.emit = 1'b1; p.kind = KIND_DIV; p.next = ST_START; p.again = 1'b1;
            end
         end
         ST_BSLASH: begin
            p.next = ST_START;
            if (it.cls == CC_NEWLINE) p.newline = 1'b1;
            else p.again = 1'b1;
         end
         ST_LINECMT: begin
            if (it.cls == CC_EOF) begin
               p.emit = 1'b1; p.kind = KIND_EOF; p.next = ST_START;
            end else if (it.cls == CC_NEWLINE) begin
               p.newline = 1'b1; p.next = ST_START;
            end
         end
         ST_BLOCK: begin
            if (it.cls == CC_EOF) begin
               p.emit = 1'b1; p.kind = KIND_ERROR; p.next = ST_START;
            end else if (it.cls == CC_STAR) p.next = ST_BLOCKSTAR;
            else if (it.cls == CC_NEWLINE) p.newline = 1'b1;
         end
         ST_BLOCKSTAR: begin
            if (it.cls == CC_EOF) begin
               p.emit = 1'b1; p.kind = KIND_ERROR; p.next = ST_START;
            end else if (it.cls == CC_SLASH) p.next = ST_START;
            else if (it.cls != CC_STAR) begin
               p.newline = (it.cls == CC_NEWLINE);
               p.next    = ST_BLOCK;
            end
         end
         default: begin
            // start state
            p.start = 1'b1;
            p.next  = ST_START;
            case (it.cls)
               CC_EOF: begin
                  p.emit = 1'b1; p.kind = KIND_EOF;
               end
               CC_DIGIT: begin
                  p.emit = 1'b1; p.kind = KIND_CHAR; p.ch = it.ch; p.next = ST_NUM;
               end
               CC_ALPHA: begin
                  p.emit = 1'b1; p.kind = KIND_CHAR; p.ch = it.ch; p.next = ST_ID;
               end
               CC_BLANK:   p.emit = 1'b0;
               CC_NEWLINE: p.newline = 1'b1;
               CC_BSLASH:  p.next = ST_BSLASH;
               CC_SLASH:   p.next = ST_SLASH;
               CC_LT:      p.next = ST_LT;
               CC_GT:      p.next = ST_GT;
               CC_COLON:   p.next = ST_ASSIGN;
               CC_STAR, CC_EQ, CC_OP: begin
                  p.emit = 1'b1; p.kind = it.op_kind;
               end
               default: begin
                  p.emit = 1'b1; p.kind = KIND_OTHER; p.ch = it.ch;
               end
            endcase
         end
      endcase
      return p;
   endfunction

   // both passes of one item; the second one, used only when the first sets again, runs from start
   always_comb begin
      p1     = scan_pass(state_ff, mid_data);
      p2     = scan_pass(p1.next, mid_data);
      second = p1.again & p2.emit;
      both   = p1.emit & second;

      r1.token_kind   = p1.kind;
      r1.char_value   = p1.ch;
      r1.line_number  = line_ff;
      r1.start_column = p1.start ? mid_data.column : tok_col_ff;
      r1.last_of_run  = ~second;

      r2.token_kind   = p2.kind;
      r2.char_value   = p2.ch;
      r2.line_number  = line_ff;
      r2.start_column = mid_data.column;
      r2.last_of_run  = 1'b1;
   end

   // outputs
   always_comb begin
      out_push = 1'b0;
      out_data = r1;
      mid_pop  = 1'b0;
      if (!mid_empty) begin
         if (phase_ff) begin
            out_push = ~out_full;
            out_data = r2;
            mid_pop  = ~out_full;
         end else if (both) begin
            out_push = ~out_full;
         end else if (p1.emit || second) begin
            out_push = ~out_full;
            out_data = p1.emit ? r1 : r2;
            mid_pop  = ~out_full;
         end else begin
            mid_pop = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      line_in    = line_ff;
      tok_col_in = tok_col_ff;
      phase_in   = phase_ff;
      if (!mid_empty && !phase_ff && both && !out_full) begin
         phase_in = 1'b1;
      end
      if (mid_pop) begin
         phase_in = 1'b0;
         state_in = p1.again ? p2.next : p1.next;
         if ((p1.newline || (p1.again && p2.newline)) && line_ff != LINE_MAX) begin
            line_in = line_ff + 1'b1;
         end
         if (p1.start || p1.again) begin
            tok_col_in = mid_data.column;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_START;
         line_ff    <= LINE_BITS'(1);
         tok_col_ff <= '0;
         phase_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         line_ff    <= line_in;
         tok_col_ff <= tok_col_in;
         phase_ff   <= phase_in;
      end
   end

`ifndef SYNTHESIS
   a_phase_has_item: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !mid_empty)
      else $error("second result pending without a queued item");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result written into a full queue");
   a_phase_pops: assert property (@(posedge clock) disable iff (reset)
      (phase_ff && !out_full) |-> mid_pop)
      else $error("item not retired after its second result");
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line count wrapped to zero");
`endif

endmodule

### tb/token_checker.sv
// token_checker: watches both queue ports of expression_lexer, predicts the token
// stream from every accepted source byte and compares each popped token field by field.
// Depends on exlex_pkg for the payload structs, token kinds, character codes and states.
module token_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  exlex_pkg::req_type req_data,
   input  logic               rsp_pop,
   input  logic               rsp_empty,
   input  exlex_pkg::rsp_type rsp_data,
   output int                 mismatch_count,
   output int                 tokens_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import exlex_pkg::*;

   // lexer state as the predictor sees it
   scan_state_type         lex_state = ST_START;
   logic                   cr_pending = 1'b0;
   logic [LINE_BITS-1:0]   line_cnt = LINE_BITS'(1);
   logic [COLUMN_BITS-1:0] col_cnt = '0;
   logic [COLUMN_BITS-1:0] tok_col = '0;

   rsp_type step_tok [2];
   int      step_len;
   rsp_type expected_tokens [$];
   int      tokens_checked = 0;

   initial begin
      mismatch_count = 0;
      tokens_outstanding = 0;
   end

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_word_start(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
   endfunction

   function automatic logic [4:0] operator_kind(input logic [7:0] c);
      case (c)
         ";":      return KIND_SEMI;
         "(":      return KIND_LPAREN;
         ")":      return KIND_RPAREN;
         "[":      return KIND_LBRACK;
         "]":      return KIND_RBRACK;
         ",":      return KIND_COMMA;
         "|":      return KIND_OR;
         "&":      return KIND_AND;
         "^":      return KIND_XOR;
         "~":      return KIND_NOT;
         CH_EQ:    return KIND_EQ;
         "+":      return KIND_PLUS;
         "-":      return KIND_MINUS;
         CH_STAR:  return KIND_MUL;
         "%":      return KIND_MOD;
         default:  return KIND_OTHER;
      endcase
   endfunction

   function automatic void add_token(input logic [4:0] kind, input logic [7:0] ch);
      step_tok[step_len] = '{token_kind: kind, char_value: ch, line_number: line_cnt,
                             start_column: tok_col, last_of_run: 1'b0};
      step_len++;
   endfunction

   function automatic void new_line();
      if (line_cnt != '1) line_cnt++;
      col_cnt = '0;
   endfunction

   // One source item in, zero to two tokens appended to expected_tokens.
   function automatic void lex_step(input req_type item);
      logic [7:0] c;
      logic       eof;
      logic       again;
      logic [4:0] op;
      rsp_type    tok;
      int         i;
      c = item.source_byte;
      eof = item.end_of_input;
      step_len = 0;
      if (!eof) begin
         if (c == CH_CR) begin
            cr_pending = 1'b1;
            c = CH_LF;
         end else if (c == CH_LF && cr_pending) begin
            cr_pending = 1'b0;
            return;
         end else begin
            cr_pending = 1'b0;
         end
      end
      if (col_cnt != '1) col_cnt++;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (lex_state)
            ST_NUM: begin
               if (!eof && is_digit(c)) begin
                  add_token(KIND_CHAR, c);
               end else begin
                  add_token(KIND_NUMBER, 8'h00);
                  lex_state = ST_START;
                  again = 1'b1;
               end
            end
            ST_ID: begin
               if (!eof && (is_word_start(c) || is_digit(c))) begin
                  add_token(KIND_CHAR, c);
               end else begin
                  add_token(KIND_IDENT, 8'h00);
                  lex_state = ST_START;
                  again = 1'b1;
               end
            end
            ST_LT, ST_GT: begin
               if (!eof && c == ((lex_state == ST_LT) ? CH_LT : CH_GT)) begin
                  add_token((lex_state == ST_LT) ? KIND_LTLT : KIND_GTGT, 8'h00);
               end else if (!eof && c == CH_EQ) begin
                  add_token((lex_state == ST_LT) ? KIND_LE : KIND_GE, 8'h00);
               end else begin
                  add_token((lex_state == ST_LT) ? KIND_LT : KIND_GT, 8'h00);
                  again = 1'b1;
               end
               lex_state = ST_START;
            end
            ST_ASSIGN: begin
               if (!eof && c == CH_EQ) begin
                  add_token(KIND_COLONEQ, 8'h00);
               end else begin
                  add_token(KIND_ERROR, 8'h00);
                  again = 1'b1;
               end
               lex_state = ST_START;
            end
            ST_SLASH: begin
               if (!eof && c == CH_SLASH) begin
                  lex_state = ST_LINECMT;
               end else if (!eof && c == CH_STAR) begin
                  lex_state = ST_BLOCK;
               end else begin
                  add_token(KIND_DIV, 8'h00);
                  lex_state = ST_START;
                  again = 1'b1;
               end
            end
            ST_BSLASH: begin
               lex_state = ST_START;
               if (!eof && c == CH_LF) new_line();
               else again = 1'b1;
            end
            ST_LINECMT: begin
               if (eof) begin
                  add_token(KIND_EOF, 8'h00);
                  lex_state = ST_START;
               end else if (c == CH_LF) begin
                  new_line();
                  lex_state = ST_START;
               end
            end
            ST_BLOCK: begin
               if (eof) begin
                  add_token(KIND_ERROR, 8'h00);
                  lex_state = ST_START;
               end else if (c == CH_STAR) begin
                  lex_state = ST_BLOCKSTAR;
               end else if (c == CH_LF) begin
                  new_line();
               end
            end
            ST_BLOCKSTAR: begin
               if (eof) begin
                  add_token(KIND_ERROR, 8'h00);
                  lex_state = ST_START;
               end else if (c == CH_SLASH) begin
                  lex_state = ST_START;
               end else if (c != CH_STAR) begin
                  if (c == CH_LF) new_line();
                  lex_state = ST_BLOCK;
               end
            end
            default: begin
               lex_state = ST_START;
               tok_col = col_cnt;
               op = operator_kind(c);
               if (eof) begin
                  add_token(KIND_EOF, 8'h00);
               end else if (is_digit(c)) begin
                  add_token(KIND_CHAR, c);
                  lex_state = ST_NUM;
               end else if (is_word_start(c)) begin
                  add_token(KIND_CHAR, c);
                  lex_state = ST_ID;
               end else if (c == CH_SPACE || c == CH_TAB) begin
                  // blank: column already moved
               end else if (c == CH_LF) begin
                  new_line();
               end else if (c == CH_BSLASH) begin
                  lex_state = ST_BSLASH;
               end else if (c == CH_SLASH) begin
                  lex_state = ST_SLASH;
               end else if (c == CH_LT) begin
                  lex_state = ST_LT;
               end else if (c == CH_GT) begin
                  lex_state = ST_GT;
               end else if (c == CH_COLON) begin
                  lex_state = ST_ASSIGN;
               end else if (op != KIND_OTHER) begin
                  add_token(op, 8'h00);
               end else begin
                  add_token(KIND_OTHER, c);
               end
            end
         endcase
      end
      for (i = 0; i < step_len; i++) begin
         tok = step_tok[i];
         tok.last_of_run = (i == step_len - 1);
         expected_tokens.push_back(tok);
      end
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      mismatch_count++;
      $display("%0t ns: token %0d %s: expected 0x%0h, got 0x%0h",
               $time, tokens_checked, what, want, got);
   endtask

   task automatic compare_token(input rsp_type got);
      rsp_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch("popped with nothing pending, token_kind", 64'd0,
                         64'(got.token_kind));
      end else begin
         want = expected_tokens.pop_front();
         if (got.token_kind !== want.token_kind)
            report_mismatch("token_kind", 64'(want.token_kind), 64'(got.token_kind));
         if (got.char_value !== want.char_value)
            report_mismatch("char_value", 64'(want.char_value), 64'(got.char_value));
         if (got.line_number !== want.line_number)
            report_mismatch("line_number", 64'(want.line_number), 64'(got.line_number));
         if (got.start_column !== want.start_column)
            report_mismatch("start_column", 64'(want.start_column),
                            64'(got.start_column));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      end
      tokens_checked++;
   endtask

   // Input side first, so a token that could follow its byte closely still finds it.
   always @(posedge clock) begin
      if (reset) begin
         lex_state = ST_START;
         cr_pending = 1'b0;
         line_cnt = LINE_BITS'(1);
         col_cnt = '0;
         tok_col = '0;
         expected_tokens.delete();
      end else begin
         if (req_push && !req_full) lex_step(req_data);
         if (rsp_pop && !rsp_empty) compare_token(rsp_data);
      end
      tokens_outstanding <= expected_tokens.size();
   end

endmodule

### tb/tb_top.sv
// tb_top: stimulus and verdict for expression_lexer; token_checker predicts and compares.
// Depends on exlex_pkg, expression_lexer and token_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import exlex_pkg::*;

   // Limit sized for the slowest correct run: longest gaps on both sides,
   // two results per item and the two long receiver stalls.
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int RANDOM_ITEMS = 1350;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    rsp_empty;
   int      mismatch_count;
   int      tokens_outstanding;

   int      items_sent = 0;
   int      cycle_count = 0;
   // sender pacing: 0 back to back, 1 random gaps, 2 mostly back to back
   int      pace_mode = 1;
   string   op_text = ";()[],|&^~=+-*%<>/:";

   expression_lexer uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   token_checker u_token_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data           (req_data),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_data           (rsp_data),
      .mismatch_count     (mismatch_count),
      .tokens_outstanding (tokens_outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle cycles before the next transfer, shared by both sides.
   function automatic int pause_cycles(input int mode);
      case (mode)
         0:       return 0;
         1:       return $urandom_range(0, 12);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
      endcase
   endfunction

   // Letters and underscore always; digits too unless this opens an identifier.
   function automatic logic [7:0] word_char(input logic lead);
      int r;
      r = $urandom_range(0, lead ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return CH_US;
      return 8'("0" + r - 53);
   endfunction

   // Called from the clocked stimulus thread. push stays high across back-to-back
   // transfers and is only dropped when a gap is drawn.
   task automatic send_item(input req_type item);
      int gap;
      gap = pause_cycles(pace_mode);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] c);
      send_item('{source_byte: c, end_of_input: 1'b0});
   endtask

   // the byte rides along with the mark and must be ignored
   task automatic send_eof();
      send_item('{source_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
   endtask

   // One lexical fragment: mostly well-formed tokens, with some noise mixed in.
   task automatic send_fragment();
      int n;
      case ($urandom_range(0, 15))
         0, 1: begin
            n = $urandom_range(1, 5);
            repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
         end
         2, 3: begin
            send_byte(word_char(1'b1));
            n = $urandom_range(0, 6);
            repeat (n) send_byte(word_char(1'b0));
         end
         4, 5, 6: begin
            n = $urandom_range(0, 24);
            if (n < 19) begin
               send_byte(op_text[n]);
            end else begin
               case (n)
                  19: begin send_byte(CH_LT); send_byte(CH_LT); end
                  20: begin send_byte(CH_LT); send_byte(CH_EQ); end
                  21: begin send_byte(CH_GT); send_byte(CH_GT); end
                  22: begin send_byte(CH_GT); send_byte(CH_EQ); end
                  default: begin send_byte(CH_COLON); send_byte(CH_EQ); end
               endcase
            end
         end
         7: send_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
         8: begin
            // LF, bare CR, or CRLF
            n = $urandom_range(0, 2);
            send_byte((n == 0) ? CH_LF : CH_CR);
            if (n == 2) send_byte(CH_LF);
         end
         9: begin
            // line comment, closed by a newline or by end of input
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            n = $urandom_range(0, 8);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 5))
               0:       send_eof();
               1:       send_byte(CH_CR);
               default: send_byte(CH_LF);
            endcase
         end
         10: begin
            // block comment; the body is heavy on stars, slashes and newlines
            send_byte(CH_SLASH);
            send_byte(CH_STAR);
            n = $urandom_range(0, 8);
            repeat (n) begin
               case ($urandom_range(0, 5))
                  0, 1:    send_byte(CH_STAR);
                  2:       send_byte(CH_LF);
                  3:       send_byte(CH_CR);
                  4:       send_byte(CH_SLASH);
                  default: send_byte(8'($urandom_range(0, 255)));
               endcase
            end
            if ($urandom_range(0, 5) == 0) begin
               send_eof();
            end else begin
               send_byte(CH_STAR);
               send_byte(CH_SLASH);
            end
         end
         11: begin
            // line continuation, or a stray backslash
            send_byte(CH_BSLASH);
            case ($urandom_range(0, 3))
               0:       send_byte(CH_LF);
               1:       send_byte(CH_CR);
               2:       send_byte(word_char(1'b1));
               default: send_byte(8'($urandom_range(0, 255)));
            endcase
         end
         12: begin
            // colon not followed by '=' is an error
            send_byte(CH_COLON);
            send_byte(word_char(1'b1));
         end
         13: send_eof();
         14: send_byte(8'($urandom_range(0, 255)));
         default: begin
            // number running straight into an identifier
            send_byte(8'("0" + $urandom_range(0, 9)));
            send_byte(word_char(1'b1));
         end
      endcase
   endtask

   // Receiver: pops with random hold-offs. Twice it stalls for a long stretch
   // while the sender keeps pushing, so both internal queues fill and
   // req_full has to push back.
   initial begin : result_drain
      int hold;
      int popped;
      int drain_mode;
      hold = 0;
      popped = 0;
      drain_mode = 1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            popped++;
            if (popped % 50 == 0) drain_mode = $urandom_range(0, 2);
            if (popped == 60 || popped == 400) hold = 300;
            else hold = pause_cycles(drain_mode);
         end
         if (hold > 0) begin
            rsp_pop <= 1'b0;
            hold--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Hard stop in case the handshake hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int random_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // byte extremes come back as plain characters
      send_byte(8'h00);
      send_byte(8'hFF);
      // identifier with a digit ended by a CRLF; the LF after the CR is dropped
      send_byte(CH_US);
      send_byte("9");
      send_byte(CH_CR);
      send_byte(CH_LF);
      // number ended by a colon; the lone colon errors and the next one forms ':='
      send_byte("7");
      send_byte(CH_COLON);
      send_byte(CH_COLON);
      send_byte(CH_EQ);
      // '<<', then a '>' cut off by end of input: GT and EOF from one transfer
      send_byte(CH_LT);
      send_byte(CH_LT);
      send_byte(CH_TAB);
      send_byte(CH_GT);
      send_eof();
      // backslash-newline is skipped; a stray backslash is dropped
      send_byte(CH_BSLASH);
      send_byte(CH_LF);
      send_byte(CH_BSLASH);
      send_byte("x");
      // identifier closed by a line comment, which end of input closes in turn
      send_byte(CH_SLASH);
      send_byte(CH_SLASH);
      send_eof();
      // end of input inside a block comment: error first, EOF on the next mark
      send_byte(CH_SLASH);
      send_byte(CH_STAR);
      send_byte(CH_LF);
      send_byte(CH_STAR);
      send_eof();
      send_eof();

      // random fragments, with the sender's pacing changing now and then
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 40) == 0) pace_mode = $urandom_range(0, 2);
         send_fragment();
      end

      // a few more tokens, back to back
      pace_mode = 0;
      repeat (40) send_fragment();
      send_eof();
      req_push <= 1'b0;

      // let the checker see the last transfer, drain, then a short quiet spell
      @(posedge clock);
      wait (tokens_outstanding == 0);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && tokens_outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
